@@ hw/rtl/bnfa_pkg.sv @@
// Shared types and constants of the bitmap next-fit allocator.
`default_nettype none

package bnfa_pkg;

    // Field widths fixed by the transaction formats.
    localparam int IDX_W    = 10;
    localparam int TOT_W    = 11;
    localparam int NUM_W    = 32;
    localparam int STATUS_W = 2;
    localparam int CMD_W    = 2;

    // Default geometry of the map.
    localparam int DEF_MAP_BITS  = 1024;
    localparam int DEF_WORD_BITS = 32;

    // Total number of usable bits after reset.
    localparam int RESET_TOTAL = 1024;

    // Width of a compare between a word base and the total, used by the finder default.
    localparam int DEF_LIMIT_W = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_TEST  = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        CFG_GROUP_SIZE  = 1'b0,
        CFG_NUMBER_BASE = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_cmd             command;
        logic [IDX_W-1:0] index;
    } t_in_item;

    typedef struct packed {
        t_status          status;
        logic [NUM_W-1:0] number;
        logic             tested_bit;
    } t_out_item;

endpackage

`default_nettype wire

@@ hw/rtl/bnfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bnfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hw/rtl/bnfa_find.sv @@
// Finds the lowest clear bit of one map word inside a window of allowed offsets.
`default_nettype none

module bnfa_find
    import bnfa_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int LIMIT_W   = DEF_LIMIT_W,
    localparam int OFF_W    = $clog2(WORD_BITS)
) (
    input  wire logic [WORD_BITS-1:0] i_word,
    input  wire logic [OFF_W-1:0]     i_lo_off,
    input  wire logic                 i_use_lo,
    input  wire logic [LIMIT_W-1:0]   i_limit,
    output logic                      o_found,
    output logic [OFF_W-1:0]          o_off
);

    // A bit qualifies when it is clear, at or above the start offset of the
    // first word, and below the number of usable bits left in this word.
    // Scanning from the top lets the lowest qualifying bit win.
    always_comb begin
        o_found = 1'b0;
        o_off   = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!i_word[b] && (!i_use_lo || OFF_W'(b) >= i_lo_off)
                    && LIMIT_W'(b) < i_limit) begin
                o_found = 1'b1;
                o_off   = OFF_W'(b);
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_next_fit_allocator_unit.sv @@
// Top level of the bitmap next-fit allocator: control sequencer around the map RAM.
`default_nettype none

// The allocation map sits in a RAM of MAP_BITS/WORD_BITS words (32 words of 32 bits by
// default), and one transaction is handled at a time. An allocate reads words, one per
// cycle, from the roving position up to the first word with a free bit or to the end of
// the group (at most 32 words by default); an allocate with no free bits goes straight
// to the result. Free and test go through an index split, a RAM read and a read-modify-
// write; a rejected free or test answers after the split. Command code 3 answers status ok.
// The result waits in an output register, so a new transaction is taken while the last
// result is still stalled. After reset and after every write of the group size the map
// is cleared by a pass of one word per cycle during which no input transaction is
// taken; configuration writes are always taken.
module bitmap_next_fit_allocator_unit
    import bnfa_pkg::*;
#(
    parameter int MAP_BITS  = DEF_MAP_BITS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_data,

    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_data,

    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire t_cfg_reg         i_cfg_index,
    input  wire logic [NUM_W-1:0] i_cfg_data
);

    localparam int NUM_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OFF_W     = $clog2(WORD_BITS);
    localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
    localparam int CMP_W     = (BASE_W > TOT_W) ? BASE_W : TOT_W;
    localparam int RECIP_K   = IDX_W;
    localparam int RECIP     = (1 << RECIP_K) / WORD_BITS;
    localparam int PROD_W    = 2 * IDX_W + 1;
    localparam logic [TOT_W-1:0] RST_TOTAL =
        TOT_W'((RESET_TOTAL > MAP_BITS) ? MAP_BITS : RESET_TOTAL);
    localparam logic [AW-1:0]    LAST_WORD = AW'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_SCAN,
        S_RMW,
        S_PUT
    } t_state;

    // Control state.
    t_state              r_state, n_state;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [NUM_W-1:0]    r_base_num, n_base_num;
    logic [TOT_W-1:0]    r_free, n_free;
    logic [AW-1:0]       r_rove_word, n_rove_word;
    logic [OFF_W-1:0]    r_rove_off, n_rove_off;
    logic                r_clr_busy, n_clr_busy;
    logic [AW-1:0]       r_clr_addr, n_clr_addr;
    logic                r_out_valid, n_out_valid;

    // Transaction payload.
    t_cmd                r_cmd, n_cmd;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [IDX_W-1:0]    r_q0, n_q0;
    logic [AW-1:0]       r_addr, n_addr;
    logic [OFF_W-1:0]    r_off, n_off;
    logic [BASE_W-1:0]   r_wbase, n_wbase;
    logic                r_first, n_first;
    t_out_item           r_res, n_res;
    t_out_item           r_out, n_out;

    // RAM port signals.
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [WORD_BITS-1:0] w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [WORD_BITS-1:0] w_rdata;

    // Handshake and helper signals.
    logic                w_in_acc;
    logic                w_out_free;
    logic [TOT_W-1:0]    w_cfg_total;
    logic [PROD_W-1:0]   w_prod;
    logic [IDX_W-1:0]    w_rem0;
    logic                w_fix;
    logic [IDX_W-1:0]    w_quot;
    logic [IDX_W-1:0]    w_rem;
    logic                w_idx_bad;
    logic [CMP_W-1:0]    w_limit;
    logic [CMP_W-1:0]    w_next_base;
    logic                w_scan_end;
    logic                w_found;
    logic [OFF_W-1:0]    w_found_off;

    // Map storage.
    bnfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Search window of the word being scanned.
    assign w_limit     = CMP_W'(r_total) - CMP_W'(r_wbase);
    assign w_next_base = CMP_W'(r_wbase) + CMP_W'(WORD_BITS);
    assign w_scan_end  = w_next_base >= CMP_W'(r_total);

    bnfa_find #(
        .WORD_BITS (WORD_BITS),
        .LIMIT_W   (CMP_W)
    ) u_find (
        .i_word   (w_rdata),
        .i_lo_off (r_rove_off),
        .i_use_lo (r_first),
        .i_limit  (w_limit),
        .o_found  (w_found),
        .o_off    (w_found_off)
    );

    // Handshakes.
    assign o_in_stall  = (r_state != S_IDLE) || r_clr_busy;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Only the low TOT_W bits of a written total count; above the map size they saturate to it.
    assign w_cfg_total = (32'(i_cfg_data[TOT_W-1:0]) > 32'(MAP_BITS))
                         ? TOT_W'(MAP_BITS) : i_cfg_data[TOT_W-1:0];

    // Index split, first half: estimate of index / WORD_BITS by a reciprocal.
    // The estimate is the true quotient or one below it.
    assign w_prod = PROD_W'(i_in_data.index) * PROD_W'(RECIP);

    // Index split, second half: remainder and a single correction step.
    assign w_rem0    = r_idx - IDX_W'(r_q0 * IDX_W'(WORD_BITS));
    assign w_fix     = w_rem0 >= IDX_W'(WORD_BITS);
    assign w_quot    = w_fix ? (r_q0 + IDX_W'(1)) : r_q0;
    assign w_rem     = w_fix ? (w_rem0 - IDX_W'(WORD_BITS)) : w_rem0;
    assign w_idx_bad = TOT_W'(r_idx) >= r_total;

    // Next-state logic of the sequencer, the clearing pass and the registers.
    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_base_num  = r_base_num;
        n_free      = r_free;
        n_rove_word = r_rove_word;
        n_rove_off  = r_rove_off;
        n_clr_busy  = r_clr_busy;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_q0        = r_q0;
        n_addr      = r_addr;
        n_off       = r_off;
        n_wbase     = r_wbase;
        n_first     = r_first;
        n_res       = r_res;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = w_rdata;
        w_raddr     = r_addr;

        // Output register drains when the receiver takes the transaction.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_cmd            = i_in_data.command;
                    n_idx            = i_in_data.index;
                    n_q0             = w_prod[RECIP_K +: IDX_W];
                    n_res.status     = ST_OK;
                    n_res.number     = '0;
                    n_res.tested_bit = 1'b0;
                    unique case (i_in_data.command)
                        CMD_ALLOC: begin
                            if (r_free == '0) begin
                                n_res.status = ST_NO_SPACE;
                                n_state      = S_PUT;
                            end else begin
                                // Start the scan at the word of the roving position.
                                n_addr  = r_rove_word;
                                w_raddr = r_rove_word;
                                n_wbase = BASE_W'(r_rove_word) * BASE_W'(WORD_BITS);
                                n_first = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_FREE, CMD_TEST: begin
                            n_state = S_SPLIT;
                        end
                        default: begin
                            n_state = S_PUT;
                        end
                    endcase
                end
            end

            S_SPLIT: begin
                n_addr  = AW'(w_quot);
                n_off   = OFF_W'(w_rem);
                w_raddr = AW'(w_quot);
                priority if (r_cmd == CMD_FREE && r_free == r_total) begin
                    n_res.status = ST_NOT_ALLOC;
                    n_state      = S_PUT;
                end else if (w_idx_bad) begin
                    n_res.status = ST_RANGE;
                    n_state      = S_PUT;
                end else begin
                    n_state = S_RMW;
                end
            end

            S_RMW: begin
                if (r_cmd == CMD_FREE) begin
                    // Clear the bit; the count grows even if the bit was clear.
                    w_we    = 1'b1;
                    w_waddr = r_addr;
                    w_wdata = w_rdata & ~(WORD_BITS'(1) << r_off);
                    n_free  = r_free + TOT_W'(1);
                end else begin
                    n_res.tested_bit = w_rdata[r_off];
                end
                n_state = S_PUT;
            end

            S_SCAN: begin
                priority if (w_found) begin
                    // Claim the bit and move the roving position onto it.
                    w_we         = 1'b1;
                    w_waddr      = r_addr;
                    w_wdata      = w_rdata | (WORD_BITS'(1) << w_found_off);
                    n_free       = r_free - TOT_W'(1);
                    n_rove_word  = r_addr;
                    n_rove_off   = w_found_off;
                    n_res.number = r_base_num + NUM_W'(r_wbase) + NUM_W'(w_found_off);
                    n_state      = S_PUT;
                end else if (w_scan_end) begin
                    // No wrap-around: the search restarts from zero next time.
                    n_rove_word  = '0;
                    n_rove_off   = '0;
                    n_res.status = ST_NO_SPACE;
                    n_state      = S_PUT;
                end else begin
                    n_addr  = r_addr + AW'(1);
                    w_raddr = r_addr + AW'(1);
                    n_wbase = r_wbase + BASE_W'(WORD_BITS);
                    n_first = 1'b0;
                end
            end

            S_PUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Clearing pass, one word per cycle.
        if (r_clr_busy) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
            if (r_clr_addr == LAST_WORD) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_addr = r_clr_addr + AW'(1);
            end
        end

        // Configuration writes.
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GROUP_SIZE: begin
                    n_total     = w_cfg_total;
                    n_free      = w_cfg_total;
                    n_rove_word = '0;
                    n_rove_off  = '0;
                    n_clr_busy  = 1'b1;
                    n_clr_addr  = '0;
                end
                CFG_NUMBER_BASE: begin
                    n_base_num = i_cfg_data;
                end
                default: begin
                    n_base_num = r_base_num;
                end
            endcase
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= RST_TOTAL;
            r_base_num  <= '0;
            r_free      <= RST_TOTAL;
            r_rove_word <= '0;
            r_rove_off  <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_base_num  <= n_base_num;
            r_free      <= n_free;
            r_rove_word <= n_rove_word;
            r_rove_off  <= n_rove_off;
            r_clr_busy  <= n_clr_busy;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_cmd   <= n_cmd;
        r_idx   <= n_idx;
        r_q0    <= n_q0;
        r_addr  <= n_addr;
        r_off   <= n_off;
        r_wbase <= n_wbase;
        r_first <= n_first;
        r_res   <= n_res;
        r_out   <= n_out;
    end

`ifndef NO_ASSERTIONS
    // The free count can never exceed the number of usable bits.
    a_free_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_total)
        else $error("free count above total");

    // A scan never looks at a word that starts at or beyond the total.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CMP_W'(r_wbase) < CMP_W'(r_total)))
        else $error("scan past the end of the group");

    // Checks that the clearing pass does not overlap a transaction in progress; the block itself does not enforce it.
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> (r_state == S_IDLE))
        else $error("clearing pass during a transaction");
`endif

endmodule

`default_nettype wire

@@ tb/bnfa_checker.sv @@
// Checker for the bitmap next-fit allocator: tracks the group state and compares every result.
module bnfa_checker
    import bnfa_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire t_in_item         i_in_data,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire t_out_item        i_out_data,
    input  wire logic             i_cfg_valid,
    input  wire logic             i_cfg_ready,
    input  wire t_cfg_reg         i_cfg_index,
    input  wire logic [NUM_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int MAP_BITS = DEF_MAP_BITS;

    // Shadow copy of the group: occupancy map, free count, roving position and settings.
    logic [MAP_BITS-1:0] occupied;
    logic [TOT_W-1:0]    group_size;
    logic [TOT_W-1:0]    free_bits;
    logic [IDX_W-1:0]    rover;
    logic [NUM_W-1:0]    base_number;

    // Answers owed by the block, oldest first.
    t_out_item answers_due[$];
    int        faults = 0;

    assign o_fail_count = faults;

    // A new group size empties the map; sizes above the map are clipped to the map.
    function automatic void resize_group(logic [TOT_W-1:0] size);
        group_size  = (size > MAP_BITS) ? TOT_W'(MAP_BITS) : size;
        occupied    = '0;
        free_bits   = group_size;
        rover       = '0;
    endfunction

    // Work out the answer to one request and update the shadow group.
    function automatic t_out_item settle_request(t_in_item req);
        t_out_item ans;
        int        pos;
        ans = '0;
        case (req.command)
            CMD_ALLOC: begin
                if (free_bits == 0) begin
                    ans.status = ST_NO_SPACE;
                end else begin
                    // Next fit: look upward from the rover, never wrapping around.
                    pos = int'(rover);
                    while (pos < int'(group_size) && occupied[pos]) begin
                        pos++;
                    end
                    if (pos >= int'(group_size)) begin
                        rover      = '0;
                        ans.status = ST_NO_SPACE;
                    end else begin
                        occupied[pos] = 1'b1;
                        free_bits     = free_bits - 1'b1;
                        rover         = IDX_W'(pos);
                        ans.number    = base_number + NUM_W'(pos);
                    end
                end
            end
            CMD_FREE: begin
                if (free_bits == group_size) begin
                    ans.status = ST_NOT_ALLOC;
                end else if (req.index >= group_size) begin
                    ans.status = ST_RANGE;
                end else begin
                    // The count goes up even when the bit was already clear.
                    occupied[req.index] = 1'b0;
                    free_bits           = free_bits + 1'b1;
                end
            end
            CMD_TEST: begin
                if (req.index >= group_size) begin
                    ans.status = ST_RANGE;
                end else begin
                    ans.tested_bit = occupied[req.index];
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    task automatic compare_field(string field, logic [NUM_W-1:0] want, logic [NUM_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            faults++;
        end
    endtask

    // Results are matched before new requests are taken in, since they can only be older.
    always @(posedge i_clk) begin : watch
        t_out_item due;
        if (!i_rst_n) begin
            base_number = '0;
            resize_group(TOT_W'(RESET_TOTAL));
            answers_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    faults++;
                end else begin
                    due = answers_due.pop_front();
                    compare_field("status", NUM_W'(due.status), NUM_W'(i_out_data.status));
                    compare_field("number", due.number, i_out_data.number);
                    compare_field("tested_bit", NUM_W'(due.tested_bit),
                                  NUM_W'(i_out_data.tested_bit));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_GROUP_SIZE) begin
                    resize_group(i_cfg_data[TOT_W-1:0]);
                end else begin
                    base_number = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                answers_due.push_back(settle_request(i_in_data));
            end
        end
        o_pending <= answers_due.size();
    end

endmodule

@@ tb/tb_bitmap_next_fit_allocator_unit.sv @@
// Testbench top for the bitmap next-fit allocator: stimulus, flow control and verdict.
module tb_bitmap_next_fit_allocator_unit;
    import bnfa_pkg::*;

    localparam int   LONG_HOLD      = 150;
    localparam int   DRAIN_CYCLES   = 40;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   PHASES         = 10;
    localparam t_cmd CMD_SPARE      = t_cmd'(2'd3);

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    t_cfg_reg         i_cfg_index;
    logic [NUM_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int holds_done    = 0;
    int quiet_cycles  = 0;
    int group_limit   = RESET_TOTAL;

    // Group sizes of the random phases, the extremes among them.
    int phase_total[PHASES] = '{1, 32, 33, 2047, 7, 0, 64, 31, 1024, 2};

    bitmap_next_fit_allocator_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    bnfa_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side: random stall bursts, plus a long hold-off when one is requested.
    initial begin
        forever begin
            if (holds_done != hold_requests) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("bitmap_next_fit_allocator_unit test failed");
        $finish;
    end

    // Offer one request, after an optional gap, and hold it until it is taken.
    task automatic send_item(input t_cmd cmd, input logic [IDX_W-1:0] idx);
        t_in_item req;
        req.command = cmd;
        req.index   = idx;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Register writes wait until every answer is back and the block has settled.
    task automatic write_register(input t_cfg_reg which, input logic [NUM_W-1:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (which == CFG_GROUP_SIZE) begin
            group_limit = (value[TOT_W-1:0] > DEF_MAP_BITS) ? DEF_MAP_BITS
                                                            : int'(value[TOT_W-1:0]);
        end
    endtask

    // Mostly allocations and in-range frees and tests, with some stray indexes.
    task automatic random_item();
        int               pick;
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            cmd = CMD_ALLOC;
        end else if (pick < 75) begin
            cmd = CMD_FREE;
        end else if (pick < 97) begin
            cmd = CMD_TEST;
        end else begin
            cmd = CMD_SPARE;
        end
        if (group_limit > 0 && $urandom_range(0, 4) != 0) begin
            idx = IDX_W'($urandom_range(0, group_limit - 1));
        end else begin
            idx = IDX_W'($urandom());
        end
        send_item(cmd, idx);
    endtask

    initial begin : stimulus
        logic [NUM_W-1:0] base;
        int               pick;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_GROUP_SIZE;
        i_cfg_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full group after reset: edge indexes, first allocations, double free, spare code.
        send_item(CMD_TEST, 10'd0);
        send_item(CMD_TEST, 10'd1023);
        send_item(CMD_FREE, 10'd5);
        send_item(CMD_ALLOC, 10'd0);
        send_item(CMD_ALLOC, 10'd1023);
        send_item(CMD_TEST, 10'd1);
        send_item(CMD_FREE, 10'd1);
        send_item(CMD_FREE, 10'd1);
        send_item(CMD_SPARE, 10'h3FF);

        // Tiny group at the top base: fill it, overrun it, and hit the end without wrapping.
        write_register(CFG_NUMBER_BASE, 32'hFFFF_FC00);
        write_register(CFG_GROUP_SIZE, 32'd5);
        repeat (6) send_item(CMD_ALLOC, 10'd0);
        send_item(CMD_FREE, 10'd7);
        send_item(CMD_TEST, 10'd5);
        send_item(CMD_FREE, 10'd2);
        send_item(CMD_ALLOC, 10'd0);
        send_item(CMD_ALLOC, 10'd0);
        send_item(CMD_TEST, 10'd2);

        // Empty group: nothing can be allocated, freed or tested.
        write_register(CFG_GROUP_SIZE, 32'd0);
        send_item(CMD_ALLOC, 10'd0);
        send_item(CMD_FREE, 10'd0);
        send_item(CMD_TEST, 10'd0);

        // Oversized total is clipped to the whole map.
        write_register(CFG_GROUP_SIZE, 32'd2047);
        send_item(CMD_ALLOC, 10'd0);
        send_item(CMD_FREE, 10'd1023);
        send_item(CMD_TEST, 10'd1023);

        // Random phases over several group sizes and bases; the tail runs without idling.
        for (int p = 0; p < PHASES; p++) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                base = '0;
            end else if (pick == 1) begin
                base = 32'hFFFF_FC00;
            end else begin
                base = $urandom_range(0, 32'hFFFF_FC00);
            end
            write_register(CFG_NUMBER_BASE, base);
            write_register(CFG_GROUP_SIZE, NUM_W'(phase_total[p]));
            idle_on = (p < PHASES - 2) && (p % 4 != 3);
            if (p == 1) begin
                hold_requests++;
            end
            repeat ((phase_total[p] == 0) ? 12 : 52) random_item();
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("bitmap_next_fit_allocator_unit test passed");
        end else begin
            $display("bitmap_next_fit_allocator_unit test failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/bnfa_pkg.sv
hw/rtl/bnfa_ram.sv
hw/rtl/bnfa_find.sv
hw/rtl/bitmap_next_fit_allocator_unit.sv
tb/bnfa_checker.sv
tb/tb_bitmap_next_fit_allocator_unit.sv
